[hw/rtl/iirdf1_pkg.sv]
// Shared types and constants for the direct form I IIR filter.
// No dependencies; imported by iir_direct_form_one_filter.
package iirdf1_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int FRAC_W    = 14;
  localparam int NUM_COEF  = 7;
  localparam int IDX_W     = 3;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  // Seven products of at most 2^32 each fit in 36 bits plus sign; keep margin.
  localparam int ACC_W     = PROD_W + 4;
  localparam int SHIFT_W   = ACC_W - FRAC_W;
  localparam int STEP_W    = 3;

  // Coefficient register indexes.
  localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_B3 = 3'd3;
  localparam logic [IDX_W-1:0] REG_A1 = 3'd4;
  localparam logic [IDX_W-1:0] REG_A2 = 3'd5;
  localparam logic [IDX_W-1:0] REG_A3 = 3'd6;

  localparam logic signed [COEF_W-1:0] B0_RESET = 18'sd16384;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

endpackage

[hw/rtl/iir_direct_form_one_filter.sv]
// Third-order direct form I IIR filter on one shared 18x16 multiplier.
// Depends on iirdf1_pkg for widths, types and register indexes.
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  in_sample_in, in_clear_history
//   out_      output     out_valid / out_stall out_sample_out
//   cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each sample is accepted, then its seven taps go in turn through the single
// multiplier, the last product is added in the drain state, and the result
// is rounded, saturated and registered while the histories shift.
// Reset (rst_n low, synchronous) clears both histories and the controller and
// loads b0 = 1.0 with all other coefficients zero.
// in_stall is high while a sample is in progress; a finished result waits in
// the sequencer if the output register is still held by out_stall.
module iir_direct_form_one_filter
  import iirdf1_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_sample_in,
  input  logic                in_clear_history,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [SAMPLE_W-1:0] out_sample_out,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [COEF_W-1:0]   cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_COEF - 1);
  localparam sample_t SAT_HI = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAT_LO = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam acc_t    HALF   = acc_t'(1) <<< (FRAC_W - 1);

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  coef_t             coef_r [NUM_COEF];
  sample_t           x_r;
  sample_t           xh_r [3];
  sample_t           yh_r [3];
  prod_t             prod_r, prod_nxt;
  logic              prod_vld_r, prod_vld_nxt;
  logic              prod_sub_r, prod_sub_nxt;
  acc_t              acc_r, acc_nxt;
  logic              out_valid_r;
  sample_t           out_sample_r;

  coef_t             mul_coef;
  sample_t           mul_data;
  acc_t              prod_ext;
  acc_t              rnd_sum;
  logic signed [SHIFT_W-1:0] shifted;
  sample_t           y_sat;
  logic              in_fire;
  logic              out_load;

  assign in_stall       = (state_r != ST_IDLE);
  assign in_fire        = in_valid && !in_stall;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // Operand select for the shared multiplier: b0 on the new sample, then
  // alternating feedforward and feedback taps, oldest last.
  always_comb begin
    mul_coef     = coef_r[REG_B0];
    mul_data     = x_r;
    prod_sub_nxt = 1'b0;
    case (step_r)
      3'd0: begin
        mul_coef = coef_r[REG_B0];
        mul_data = x_r;
      end
      3'd1: begin
        mul_coef = coef_r[REG_B1];
        mul_data = xh_r[0];
      end
      3'd2: begin
        mul_coef     = coef_r[REG_A1];
        mul_data     = yh_r[0];
        prod_sub_nxt = 1'b1;
      end
      3'd3: begin
        mul_coef = coef_r[REG_B2];
        mul_data = xh_r[1];
      end
      3'd4: begin
        mul_coef     = coef_r[REG_A2];
        mul_data     = yh_r[1];
        prod_sub_nxt = 1'b1;
      end
      3'd5: begin
        mul_coef = coef_r[REG_B3];
        mul_data = xh_r[2];
      end
      3'd6: begin
        mul_coef     = coef_r[REG_A3];
        mul_data     = yh_r[2];
        prod_sub_nxt = 1'b1;
      end
      default: begin
        mul_coef = coef_r[REG_B0];
        mul_data = x_r;
      end
    endcase
    prod_nxt = mul_coef * mul_data;
  end

  // Accumulate the registered product, add or subtract by tap kind.
  assign prod_ext = acc_t'(prod_r);
  always_comb begin
    acc_nxt = acc_r;
    if (prod_vld_r) begin
      acc_nxt = prod_sub_r ? (acc_r - prod_ext) : (acc_r + prod_ext);
    end
  end

  // Round half up, drop the fraction, then clamp to the sample range.
  assign rnd_sum = acc_r + HALF;
  assign shifted = SHIFT_W'(rnd_sum >>> FRAC_W);
  always_comb begin
    if (shifted > SHIFT_W'(SAT_HI)) begin
      y_sat = SAT_HI;
    end else if (shifted < SHIFT_W'(SAT_LO)) begin
      y_sat = SAT_LO;
    end else begin
      y_sat = shifted[SAMPLE_W-1:0];
    end
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    prod_vld_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_fire) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_vld_nxt = 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_DRAIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      prod_vld_r <= prod_vld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    prod_sub_r <= prod_sub_nxt;
    if (in_fire) begin
      x_r   <= in_sample_in;
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
    if (out_load) begin
      out_sample_r <= y_sat;
    end
  end

  // Coefficient registers; an index past the last tap is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= (i == int'(REG_B0)) ? B0_RESET : coef_t'(0);
      end
    end else if (cfg_valid && cfg_ready && (cfg_index <= REG_A3)) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  // Input and output histories, newest first. The clear word zeroes them
  // when the sample is taken; the shift happens once the result is final.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else if (in_fire && in_clear_history) begin
      for (int i = 0; i < 3; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else if (out_load) begin
      xh_r[2] <= xh_r[1];
      xh_r[1] <= xh_r[0];
      xh_r[0] <= x_r;
      yh_r[2] <= yh_r[1];
      yh_r[1] <= yh_r[0];
      yh_r[0] <= y_sat;
    end
  end

endmodule

[sim/iir_direct_form_one_filter_tb.sv]
// Self-checking testbench for the third-order direct form I IIR filter.
// Depends on iirdf1_pkg and iir_direct_form_one_filter; a built-in predictor
// computes every filtered sample and the monitor checks each output word.
module iir_direct_form_one_filter_tb;
  import iirdf1_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 10;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_SAMPLES = 180;
  localparam int REPORT_MAX    = 10;

  // Index past the last coefficient; the block must ignore writes to it.
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

  localparam coef_t   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    sample_t sample;
    logic    clear;
  } filter_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    coef_t            data;
  } coef_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample_in = '0;
  logic                in_clear_history = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_sample_out;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [COEF_W-1:0]   cfg_data = '0;

  // Pending stimulus and outstanding predictions.
  filter_word_t sample_queue[$];
  coef_word_t   coef_queue[$];
  sample_t      predicted_out[$];

  // Predictor state: coefficients as written, input and output histories.
  coef_t   coef_model[NUM_COEF];
  sample_t x_hist[3];
  sample_t y_hist[3];

  bit idle_on = 1'b1;
  int tx_gap_left = 0;
  int rx_gap_left = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int checked_count = 0;
  int clear_count = 0;
  int sat_count = 0;
  int setting_count = 0;

  iir_direct_form_one_filter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_in     (in_sample_in),
    .in_clear_history (in_clear_history),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_out   (out_sample_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Synchronous reset, asserted at the start only.
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Filter one sample: optional clear, seven taps, round half up, clamp.
  function automatic sample_t filter_predict(sample_t x, logic clr);
    longint acc;
    longint y;
    if (clr) begin
      x_hist = '{default: '0};
      y_hist = '{default: '0};
    end
    acc = longint'(coef_model[REG_B0]) * x
        + longint'(coef_model[REG_B1]) * x_hist[0]
        + longint'(coef_model[REG_B2]) * x_hist[1]
        + longint'(coef_model[REG_B3]) * x_hist[2]
        - longint'(coef_model[REG_A1]) * y_hist[0]
        - longint'(coef_model[REG_A2]) * y_hist[1]
        - longint'(coef_model[REG_A3]) * y_hist[2];
    // Arithmetic shift floors, so adding half an LSB rounds ties upward.
    y = (acc + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
    if (y > longint'(SAMPLE_MAX)) begin
      y = longint'(SAMPLE_MAX);
      sat_count++;
    end else if (y < longint'(SAMPLE_MIN)) begin
      y = longint'(SAMPLE_MIN);
      sat_count++;
    end
    x_hist[2] = x_hist[1];
    x_hist[1] = x_hist[0];
    x_hist[0] = x;
    y_hist[2] = y_hist[1];
    y_hist[1] = y_hist[0];
    y_hist[0] = sample_t'(y);
    return sample_t'(y);
  endfunction

  task automatic report_failure(string what);
    if (fail_count < REPORT_MAX) $display("[%0t] %s", $realtime, what);
    fail_count++;
  endtask

  // Coefficient writes: the model follows each accepted word.
  always @(posedge clk) begin : cfg_side
    coef_word_t w;
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      for (int i = 0; i < NUM_COEF; i++)
        coef_model[i] <= (i == int'(REG_B0)) ? B0_RESET : coef_t'(0);
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= REG_A3) coef_model[cfg_index] <= cfg_data;
      if (!cfg_valid || cfg_ready) begin
        if (coef_queue.size() != 0) begin
          w = coef_queue.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= w.idx;
          cfg_data  <= w.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Sample driver: predicts on each accepted word, idles in random bursts.
  always @(posedge clk) begin : tx_side
    filter_word_t w;
    int gap_next;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap_left <= 0;
      x_hist = '{default: '0};
      y_hist = '{default: '0};
    end else begin
      if (in_valid && !in_stall) begin
        predicted_out.insert(predicted_out.size(),
                             filter_predict(in_sample_in, in_clear_history));
        if (in_clear_history) clear_count++;
      end
      if (!in_valid || !in_stall) begin
        gap_next = tx_gap_left;
        if (gap_next != 0) gap_next--;
        else if (idle_on && $urandom_range(0, 7) == 0) gap_next = $urandom_range(1, 10);
        tx_gap_left <= gap_next;
        if (gap_next == 0 && sample_queue.size() != 0) begin
          w = sample_queue.pop_front();
          in_valid         <= 1'b1;
          in_sample_in     <= w.sample;
          in_clear_history <= w.clear;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started on request, counted down here.
  always @(posedge clk) begin
    if (hold_left == 0 && hold_served != hold_requests) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compares each output word with the oldest prediction.
  always @(posedge clk) begin : rx_side
    sample_t want;
    int gap_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_gap_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_out.size() == 0) begin
          report_failure($sformatf("output word %0d with no prediction waiting",
                                   $signed(out_sample_out)));
        end else begin
          want = predicted_out.pop_front();
          checked_count++;
          if (out_sample_out !== want)
            report_failure($sformatf("sample_out mismatch: expected %0d, got %0d",
                                     want, $signed(out_sample_out)));
        end
      end
      gap_next = rx_gap_left;
      if (gap_next != 0) gap_next--;
      else if (idle_on && $urandom_range(0, 7) == 0) gap_next = $urandom_range(1, 10);
      rx_gap_left <= gap_next;
      out_stall <= (gap_next != 0) || (hold_left > 1);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
               predicted_out.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic push_sample(sample_t s, logic clr);
    sample_queue.insert(sample_queue.size(), filter_word_t'{sample: s, clear: clr});
  endtask

  task automatic write_coef(logic [IDX_W-1:0] idx, coef_t val);
    coef_queue.insert(coef_queue.size(), coef_word_t'{idx: idx, data: val});
  endtask

  // Wait until every word has been sent and every result has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (coef_queue.size() != 0 || cfg_valid || sample_queue.size() != 0 || in_valid ||
           predicted_out.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int mode;
    coef_t c;
    sample_t s;
    do @(negedge clk); while (!rst_n);

    // Reset coefficients pass samples straight through.
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample('0, 1'b1);
    push_sample(16'sd1, 1'b0);
    push_sample(-16'sd1, 1'b0);
    setting_count++;
    wait_idle();

    // Gain of one half puts odd samples exactly on a rounding tie.
    write_coef(REG_B0, COEF_MAX >>> 2);
    write_coef(REG_B0, 18'sd8192);
    wait_idle();
    push_sample(16'sd1, 1'b1);
    push_sample(-16'sd1, 1'b1);
    push_sample(16'sd3, 1'b1);
    push_sample(-16'sd3, 1'b1);
    setting_count++;
    wait_idle();

    // Extreme coefficients drive the result into both clamps; the write to
    // the unused index must leave every tap alone.
    write_coef(REG_B0, COEF_MAX);
    write_coef(REG_B1, COEF_MIN);
    write_coef(REG_B2, COEF_MAX);
    write_coef(REG_B3, COEF_MIN);
    write_coef(REG_A1, COEF_MAX);
    write_coef(REG_A2, COEF_MIN);
    write_coef(REG_A3, COEF_MAX);
    write_coef(REG_NONE, COEF_MIN);
    wait_idle();
    push_sample(SAMPLE_MAX, 1'b1);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample('0, 1'b0);
    push_sample(SAMPLE_MIN, 1'b1);
    push_sample(16'sd1, 1'b0);
    push_sample('0, 1'b0);
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(-16'sd2, 1'b1);
    push_sample('0, 1'b0);
    push_sample('0, 1'b0);
    setting_count++;
    wait_idle();

    // Random phases, each with a fresh coefficient set.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      mode = phase % 4;
      for (int r = REG_B0; r <= REG_A3; r++) begin
        case (mode)
          0: c = (r >= REG_A1) ? coef_t'(int'($urandom_range(0, 8192)) - 4096)
                               : coef_t'(int'($urandom_range(0, 16384)) - 8192);
          1: c = coef_t'($urandom);
          2: case ($urandom_range(0, 3))
               0: c = COEF_MAX;
               1: c = COEF_MIN;
               2: c = '0;
               default: c = B0_RESET;
             endcase
          default: c = (r >= REG_A1) ? coef_t'(0) : coef_t'(int'($urandom_range(0, 32768)) - 16384);
        endcase
        write_coef(IDX_W'(r), c);
      end
      if ($urandom_range(0, 1) == 0) write_coef(REG_NONE, coef_t'($urandom));
      wait_idle();

      // One phase runs with no idling, the last one too; two see a long hold.
      idle_on = !(phase == 3 || phase == RAND_PHASES - 1);
      if (phase == 2 || phase == 5) hold_requests++;
      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        case ($urandom_range(0, 3))
          1: s = sample_t'(int'($urandom_range(0, 512)) - 256);
          2: s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
          default: s = sample_t'($urandom);
        endcase
        push_sample(s, $urandom_range(0, 24) == 0);
      end
      setting_count++;
      wait_idle();
    end

    if (predicted_out.size() != 0)
      report_failure($sformatf("%0d predicted words never arrived", predicted_out.size()));
    $display("Checked %0d filtered samples over %0d coefficient settings", checked_count,
             setting_count);
    $display("including %0d history clears and %0d clamped outputs", clear_count, sat_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[iir_direct_form_one_filter.f]
hw/rtl/iirdf1_pkg.sv
hw/rtl/iir_direct_form_one_filter.sv
sim/iir_direct_form_one_filter_tb.sv
